[sv/ltc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the line buffer tab compressor.
package ltc_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int IDX_W = $clog2(LINE_CAPACITY);
  localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
  localparam logic [FILL_W-1:0] FLUSH_AT = FILL_W'(LINE_CAPACITY - 9);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_EOR = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_TAB  = 2'd1,
    CMD_EOR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

endpackage

[sv/ltc_if.sv]
`timescale 1ns / 1ps
// Word channels of the line buffer tab compressor.
interface ltc_in_if;
  logic       valid;
  logic       ready;
  logic       fault;
  logic [7:0] char_in;

  modport source (output valid, output fault, output char_in, input ready);
  modport sink (input valid, input fault, input char_in, output ready);
endinterface

interface ltc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

[sv/ltc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input words, drops faulted and null words, classifies the rest.
module ltc_front (
  ltc_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ltc_pkg::cmd_t push_cmd_o
);

  assign in_i.ready = !q_full_i;
  assign push_o = in_i.valid && !q_full_i && !in_i.fault && (in_i.char_in != ltc_pkg::CH_NUL);

  always_comb begin
    push_cmd_o.data = in_i.char_in;
    if (in_i.char_in == ltc_pkg::CH_EOR) begin
      push_cmd_o.kind = ltc_pkg::CMD_EOR;
    end else if (in_i.char_in == ltc_pkg::CH_TAB) begin
      push_cmd_o.kind = ltc_pkg::CMD_TAB;
    end else begin
      push_cmd_o.kind = ltc_pkg::CMD_CHAR;
    end
  end

endmodule

[sv/ltc_queue.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the line engine.
module ltc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ltc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output ltc_pkg::cmd_t cmd_o,
  input  logic          ready_i
);

  ltc_pkg::cmd_t                 slot_q [ltc_pkg::QUEUE_DEPTH];
  logic [ltc_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [ltc_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          pop;

  assign full_o = (cnt_q == ltc_pkg::QCNT_W'(ltc_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o = slot_q[rd_q];
  assign pop = valid_o && ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ltc_pkg::QPTR_W'(ltc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == ltc_pkg::QPTR_W'(ltc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

[sv/ltc_back.sv]
`timescale 1ns / 1ps
// Line engine: owns the line store, expands tabs, compresses and flushes lines.
module ltc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ltc_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  ltc_out_if.source     out_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TAB   = 5'b00010,
    S_FLUSH = 5'b00100,
    S_COMP  = 5'b01000,
    S_NL    = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [ltc_pkg::FILL_W-1:0]   fill_q, fill_d, pos_q, pos_d, fill_inc, pos_inc;
  logic [2:0]                   tabs_q, tabs_d;
  logic [3:0]                   pend_q, pend_d, pend_n;
  logic [7:0]                   line_mem [ltc_pkg::LINE_CAPACITY];
  logic [7:0]                   rd_q;
  logic                         we, re, adv;
  logic [ltc_pkg::IDX_W-1:0]    raddr;
  logic [7:0]                   wdata;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q;
  logic                         out_last_q;
  logic                         slot_free, emit, emit_last;
  logic [7:0]                   emit_byte;

  assign slot_free = !out_valid_q || out_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign fill_inc = fill_q + 1'b1;
  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    pos_d = pos_q;
    tabs_d = tabs_q;
    pend_d = pend_q;
    pend_n = pend_q;
    we = 1'b0;
    re = 1'b0;
    adv = 1'b0;
    raddr = '0;
    wdata = ltc_pkg::CH_SP;
    emit = 1'b0;
    emit_last = 1'b0;
    emit_byte = ltc_pkg::CH_SP;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            ltc_pkg::CMD_CHAR: begin
              we = 1'b1;
              wdata = cmd_i.data;
              fill_d = fill_inc;
              if (fill_inc >= ltc_pkg::FLUSH_AT) begin
                re = 1'b1;
                pos_d = '0;
                state_d = S_FLUSH;
              end
            end
            ltc_pkg::CMD_TAB: begin
              we = 1'b1;
              fill_d = fill_inc;
              if (fill_inc[2:0] != 3'd0) begin
                state_d = S_TAB;
              end else if (fill_inc >= ltc_pkg::FLUSH_AT) begin
                re = 1'b1;
                pos_d = '0;
                state_d = S_FLUSH;
              end
            end
            ltc_pkg::CMD_EOR: begin
              pos_d = '0;
              tabs_d = '0;
              pend_d = '0;
              if (fill_q == '0) begin
                state_d = S_NL;
              end else begin
                re = 1'b1;
                state_d = S_COMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TAB: begin
        we = 1'b1;
        fill_d = fill_inc;
        if (fill_inc[2:0] == 3'd0) begin
          if (fill_inc >= ltc_pkg::FLUSH_AT) begin
            re = 1'b1;
            pos_d = '0;
            state_d = S_FLUSH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_byte = rd_q;
          emit_last = (pos_inc == fill_q);
          if (pos_inc == fill_q) begin
            fill_d = '0;
            state_d = S_IDLE;
          end else begin
            pos_d = pos_inc;
            re = 1'b1;
            raddr = pos_inc[ltc_pkg::IDX_W-1:0];
          end
        end
      end
      S_COMP: begin
        if (rd_q == ltc_pkg::CH_SP) begin
          pend_n = pend_q + 1'b1;
          adv = 1'b1;
        end else if (tabs_q != 3'd0) begin
          if (slot_free) begin
            emit = 1'b1;
            emit_byte = ltc_pkg::CH_TAB;
            tabs_d = tabs_q - 1'b1;
          end
        end else if (pend_q != 4'd0) begin
          if (slot_free) begin
            emit = 1'b1;
            emit_byte = ltc_pkg::CH_SP;
            pend_d = pend_q - 1'b1;
          end
        end else if (slot_free) begin
          emit = 1'b1;
          emit_byte = rd_q;
          pend_n = '0;
          adv = 1'b1;
        end
        if (adv) begin
          if (pos_inc == fill_q) begin
            state_d = S_NL;
          end else begin
            re = 1'b1;
            raddr = pos_inc[ltc_pkg::IDX_W-1:0];
            pos_d = pos_inc;
            if ((pos_inc[2:0] == 3'd0) && (pend_n != 4'd0)) begin
              tabs_d = tabs_q + 1'b1;
              pend_d = '0;
            end else begin
              pend_d = pend_n;
            end
          end
        end
      end
      S_NL: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_byte = ltc_pkg::CH_EOR;
          emit_last = 1'b1;
          fill_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      pos_q <= '0;
      tabs_q <= '0;
      pend_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      pos_q <= pos_d;
      tabs_q <= tabs_d;
      pend_q <= pend_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      line_mem[fill_q[ltc_pkg::IDX_W-1:0]] <= wdata;
    end
    if (re) begin
      rd_q <= line_mem[raddr];
    end
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last = out_last_q;

endmodule

[sv/line_buffer_tab_compressor.sv]
`timescale 1ns / 1ps
// Line buffer tab compressor: front end, command queue and line engine.
// Throughput: one stored character per cycle while the engine is idle; a tab expands in the
// tab state to spaces up to the next multiple of eight. On a line end the compress state reads
// the store and emits tabs, spaces and bytes, then the newline state emits the newline; a raw
// flush emits the stored bytes. Output words are held in a register while stalled. Reset
// (async, active low) clears queue and line, not the store contents.
module line_buffer_tab_compressor (
  input  logic      clk_i,
  input  logic      rst_ni,
  ltc_in_if.sink    in_i,
  ltc_out_if.source out_o
);

  logic          q_full, push, cmd_valid, cmd_ready;
  ltc_pkg::cmd_t push_cmd, cmd;

  ltc_front u_front (
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ltc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (cmd_valid),
    .cmd_o      (cmd),
    .ready_i    (cmd_ready)
  );

  ltc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule
